[rtl/core/hpd_pkg.sv]
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types and fixed field widths of the Huffman prefix decoder.
// ----------------------------------------------------------------------------
package hpd_pkg;

  localparam int unsigned CODE_W      = 16;
  localparam int unsigned ENT_LEN_W   = 5;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_W       = 32;
  // wide enough for any running length up to 32 and any entry length
  localparam int unsigned LEN_CMP_W   = 6;

  // operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  entry_index;
    logic [CODE_W-1:0] entry_code;
    logic [ENT_LEN_W-1:0] entry_length;
    logic [SYM_W-1:0]  entry_symbol;
    logic [BYTE_W-1:0] coded_byte;
  } in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic             code_overflow;
    logic             last;
  } out_t;

  // one table slot as held in the memory
  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic [ENT_LEN_W-1:0] length;
    logic [SYM_W-1:0]     symbol;
  } entry_t;

  // request from the decode sequencer to the result buffer
  typedef struct packed {
    logic             push;
    logic             finish;
    logic [SYM_W-1:0] symbol;
    logic             overflow;
  } res_req_t;

  // status back from the result buffer
  typedef struct packed {
    logic ready;
    logic pending;
  } res_sts_t;

endpackage

[rtl/core/hpd_table.sv]
// ----------------------------------------------------------------------------
// hpd_table
// Code table memory, one write and one registered read per cycle, with
// per-slot valid flags cleared at reset.
// ----------------------------------------------------------------------------
module hpd_table import hpd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 128,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_entry_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_entry_o,
  output logic          rd_valid_o
);

  entry_t                   mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  entry_t                   rd_entry_q;
  logic                     rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

[rtl/core/hpd_result_buf.sv]
// ----------------------------------------------------------------------------
// hpd_result_buf
// Holds the newest result back until the next one or the end of the byte
// shows whether it is the last, then hands it to the output register.
// ----------------------------------------------------------------------------
module hpd_result_buf import hpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  res_req_t req_i,
  output res_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_t     out_data_o
);

  logic             pend_q, pend_d;
  logic [SYM_W-1:0] pend_sym_q, pend_sym_d;
  logic             pend_ovf_q, pend_ovf_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic             out_free;
  logic             ready;

  assign out_free = !out_valid_q || out_ready_i;
  assign ready    = !pend_q || out_free;

  always_comb begin
    pend_d      = pend_q;
    pend_sym_d  = pend_sym_q;
    pend_ovf_d  = pend_ovf_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ready && (req_i.push || req_i.finish)) begin
      if (pend_q) begin
        out_valid_d        = 1'b1;
        out_d.symbol_out   = pend_sym_q;
        out_d.code_overflow = pend_ovf_q;
        out_d.last         = req_i.finish;
      end
      pend_d = req_i.push;
      if (req_i.push) begin
        pend_sym_d = req_i.symbol;
        pend_ovf_d = req_i.overflow;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    pend_ovf_q <= pend_ovf_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.ready   = ready;
  assign sts_o.pending = pend_q;
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;

endmodule

[rtl/core/huffman_prefix_decoder_unit.sv]
// ----------------------------------------------------------------------------
// huffman_prefix_decoder_unit
// Bit-serial Huffman prefix decoder: loads a code table, then shifts each
// coded byte in one bit at a time and scans the table for an exact match.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i total bits
//
//  A load transaction is written into the table straight from idle. A decode
//  transaction takes, per coded bit, a step, a table scan (stopping at the
//  first matching slot) and the hand-over of any result; the table memory
//  has a single read port, so the scan reads one slot at a time.
//  Reset clears the decode state, the bit total and all table valid flags;
//  no clearing pass is needed.
//  A stalled output holds the sequencer at its next result hand-over; the
//  input is taken only when the previous byte is fully processed.
//
module huffman_prefix_decoder_unit import hpd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 128,
  parameter int unsigned MAX_CODE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned RLW = $clog2(MAX_CODE_BITS + 1);
  // compare width: entry codes and the running code side by side
  localparam int unsigned CW  = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam int unsigned BCW = $clog2(BYTE_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_PUSH,
    ST_FLUSH
  } state_e;

  state_e                   state_q, state_d;
  logic [BYTE_W-1:0]        byte_q, byte_d;        // bit shifter, bit 0 next
  logic [BCW-1:0]           bitcnt_q, bitcnt_d;    // bits taken from byte
  logic [CFG_W-1:0]         consumed_q, consumed_d;
  logic [CFG_W-1:0]         total_q;
  logic [MAX_CODE_BITS-1:0] rcode_q, rcode_d;
  logic [RLW-1:0]           rlen_q, rlen_d;
  logic [AW:0]              addr_q, addr_d;        // next slot to read
  logic                     chk_q, chk_d;          // read data is live
  logic                     chk_last_q, chk_last_d;
  logic [SYM_W-1:0]         res_sym_q, res_sym_d;
  logic                     res_ovf_q, res_ovf_d;

  logic        in_acc;
  logic        tbl_we;
  logic        issue;
  entry_t      rd_entry;
  logic        rd_valid;
  logic [CW-1:0] len_mask;
  logic        len_eq;
  logic        code_eq;
  logic        hit;
  res_req_t    req;
  res_sts_t    sts;
  entry_t      wr_entry;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // loads go straight into the table; slots past the end are dropped
  assign tbl_we = in_acc && (in_data_i.operation == OP_LOAD)
                  && (9'(in_data_i.entry_index) < 9'(TABLE_ENTRIES));
  assign wr_entry.code   = in_data_i.entry_code;
  assign wr_entry.length = in_data_i.entry_length;
  assign wr_entry.symbol = in_data_i.entry_symbol;

  assign issue = (state_q == ST_SCAN) && (addr_q < (AW+1)'(TABLE_ENTRIES));

  hpd_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (tbl_we),
    .wr_addr_i  (AW'(in_data_i.entry_index)),
    .wr_entry_i (wr_entry),
    .rd_en_i    (issue),
    .rd_addr_i  (addr_q[AW-1:0]),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid)
  );

  // entry code bits above its length take no part in the match
  always_comb begin
    for (int b = 0; b < int'(CW); b++) begin
      len_mask[b] = (b < int'(rd_entry.length));
    end
  end

  // lengths of zero or above the maximum never equal the running length
  assign len_eq  = (LEN_CMP_W'(rd_entry.length) == LEN_CMP_W'(rlen_q));
  assign code_eq = ((CW'(rd_entry.code) & len_mask) == CW'(rcode_q));
  assign hit     = chk_q && rd_valid && len_eq && code_eq;

  always_comb begin
    state_d    = state_q;
    byte_d     = byte_q;
    bitcnt_d   = bitcnt_q;
    consumed_d = consumed_q;
    rcode_d    = rcode_q;
    rlen_d     = rlen_q;
    addr_d     = addr_q;
    chk_d      = 1'b0;
    chk_last_d = 1'b0;
    res_sym_d  = res_sym_q;
    res_ovf_d  = res_ovf_q;
    req        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.operation == OP_DECODE)) begin
          byte_d   = in_data_i.coded_byte;
          bitcnt_d = '0;
          state_d  = ST_BIT;
        end
      end

      ST_BIT: begin
        // byte used up, or stream exhausted: a partial code stays held
        if ((bitcnt_q == BCW'(BYTE_W)) || (consumed_q >= total_q)) begin
          state_d = ST_FLUSH;
        end else begin
          consumed_d = consumed_q + 1'b1;
          rcode_d    = MAX_CODE_BITS'({rcode_q, byte_q[0]});
          rlen_d     = rlen_q + 1'b1;
          byte_d     = byte_q >> 1;
          bitcnt_d   = bitcnt_q + 1'b1;
          addr_d     = '0;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // one slot read per cycle, checked in the next cycle
        chk_d      = issue;
        chk_last_d = issue && (addr_q == (AW+1)'(TABLE_ENTRIES - 1));
        if (issue) begin
          addr_d = addr_q + 1'b1;
        end
        if (hit) begin
          res_sym_d = rd_entry.symbol;
          res_ovf_d = 1'b0;
          rcode_d   = '0;
          rlen_d    = '0;
          state_d   = ST_PUSH;
        end else if (chk_q && chk_last_q) begin
          if (rlen_q >= RLW'(MAX_CODE_BITS)) begin
            // full length reached with no match
            res_sym_d = '0;
            res_ovf_d = 1'b1;
            rcode_d   = '0;
            rlen_d    = '0;
            state_d   = ST_PUSH;
          end else begin
            state_d = ST_BIT;
          end
        end
      end

      ST_PUSH: begin
        req.push     = 1'b1;
        req.symbol   = res_sym_q;
        req.overflow = res_ovf_q;
        if (sts.ready) begin
          state_d = ST_BIT;
        end
      end

      ST_FLUSH: begin
        // marks the held result as the last of this byte
        req.finish = 1'b1;
        if (sts.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    addr_q    <= addr_d;
    res_sym_q <= res_sym_d;
    res_ovf_q <= res_ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bitcnt_q   <= '0;
      consumed_q <= '0;
      total_q    <= '0;
      rcode_q    <= '0;
      rlen_q     <= '0;
      chk_q      <= 1'b0;
      chk_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      bitcnt_q   <= bitcnt_d;
      consumed_q <= consumed_d;
      rcode_q    <= rcode_d;
      rlen_q     <= rlen_d;
      chk_q      <= chk_d;
      chk_last_q <= chk_last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_data_i;
      end
    end
  end

  hpd_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // idle means the previous byte's last result has left the holding slot
  a_idle_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.pending)
    else $error("result still held while accepting input");

  a_rlen_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rlen_q <= RLW'(MAX_CODE_BITS))
    else $error("running length beyond maximum");

  a_empty_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rlen_q == '0) |-> (rcode_q == '0))
    else $error("running code not cleared with its length");

  a_decode_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.operation == OP_DECODE)) |=> !in_ready_o)
    else $error("input taken again before the byte was processed");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for huffman_prefix_decoder_unit. Loads prefix code
// tables, streams coded bytes through the decoder under random back-pressure
// and compares every decoded symbol against an in-bench walk of the table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpd_pkg::*;

  localparam int unsigned TABLE_SLOTS  = 128;
  localparam int unsigned CODE_LIMIT   = 16;
  // worst case for one decode transaction: eight full table scans plus
  // hand-over, with a little margin on top
  localparam int unsigned BUSY_CYCLES  = 8 * (TABLE_SLOTS + 3) + 2 + 16;
  localparam int unsigned RANDOM_ITEMS = 370;
  localparam int unsigned TIMEOUT_NS   = 8_000_000;
  localparam int unsigned REPORT_CAP   = 200;

  localparam logic [SYM_W-1:0] SYM_SPACE     = 8'h20;
  localparam logic [SYM_W-1:0] SYM_LINE_FEED = 8'h0A;

  // --------------------------------------------------------------------------
  // Decoded symbol ledger: mirrors the table and the running code, and holds
  // the symbols the decoder still owes us, oldest first.
  // --------------------------------------------------------------------------
  class symbol_ledger;
    logic [CFG_W-1:0]  total_bits;
    logic [CFG_W-1:0]  bits_used;
    logic [CODE_W-1:0] run_code;
    int unsigned       run_len;
    entry_t            slot_entry [TABLE_SLOTS];
    bit                slot_live  [TABLE_SLOTS];
    out_t              due_symbols [$];
    int unsigned       mismatches;

    function new();
      total_bits = '0;
      bits_used  = '0;
      run_code   = '0;
      run_len    = 0;
      mismatches = 0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
    endfunction

    function void set_total(logic [CFG_W-1:0] value);
      total_bits = value;
    endfunction

    function int unsigned pending();
      return due_symbols.size();
    endfunction

    // lowest live slot whose length and masked code equal the running code
    function bit lookup(output logic [SYM_W-1:0] sym);
      int unsigned len;
      logic [31:0] mask;
      sym = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        len = 32'(slot_entry[i].length);
        if (slot_live[i] && len != 0 && len <= CODE_LIMIT && len == run_len) begin
          mask = (32'd1 << len) - 32'd1;
          if ((32'(slot_entry[i].code) & mask) == 32'(run_code)) begin
            sym = slot_entry[i].symbol;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void absorb_item(in_t item);
      logic [SYM_W-1:0] sym;
      out_t held;
      bit   have;
      bit   hit;
      have = 1'b0;
      held = '0;
      if (item.operation == OP_LOAD) begin
        if (32'(item.entry_index) < TABLE_SLOTS) begin
          slot_entry[item.entry_index] = '{code: item.entry_code,
                                           length: item.entry_length,
                                           symbol: item.entry_symbol};
          slot_live[item.entry_index] = 1'b1;
        end
        return;
      end
      for (int b = 0; b < BYTE_W; b++) begin
        if (bits_used >= total_bits) break;
        bits_used = bits_used + 1'b1;
        run_code  = {run_code[CODE_W-2:0], item.coded_byte[b]};
        run_len++;
        hit = lookup(sym);
        if (hit || run_len >= CODE_LIMIT) begin
          if (have) due_symbols.push_back(held);
          held = '{symbol_out: sym, code_overflow: !hit, last: 1'b0};
          have = 1'b1;
          run_code = '0;
          run_len  = 0;
        end
      end
      if (have) begin
        held.last = 1'b1;
        due_symbols.push_back(held);
      end
    endfunction

    function void match_symbol(out_t got);
      out_t want;
      if (due_symbols.size() == 0) begin
        if (mismatches < REPORT_CAP)
          $display("%0t ns: result with nothing due, expected none, actual sym=%02h ovf=%0b last=%0b",
                   $time, got.symbol_out, got.code_overflow, got.last);
        mismatches++;
        return;
      end
      want = due_symbols.pop_front();
      if (got.symbol_out !== want.symbol_out || got.code_overflow !== want.code_overflow ||
          got.last !== want.last) begin
        if (mismatches < REPORT_CAP)
          $display("%0t ns: expected sym=%02h ovf=%0b last=%0b, actual sym=%02h ovf=%0b last=%0b",
                   $time, want.symbol_out, want.code_overflow, want.last,
                   got.symbol_out, got.code_overflow, got.last);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Everything starts at a known value.
  // --------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  // idle percentages, switched between phases
  int unsigned send_gap_pct   = 9;
  int unsigned recv_stall_pct = 82;
  int unsigned items_sent     = 0;
  int unsigned tables_built   = 0;

  symbol_ledger ledger;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  huffman_prefix_decoder_unit #(
    .TABLE_ENTRIES (TABLE_SLOTS),
    .MAX_CODE_BITS (CODE_LIMIT)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Result side: random stalls, and every completed transaction is checked.
  // Values are sampled as they stood just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.match_symbol(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  // load transaction; the unused byte field carries noise
  function automatic in_t load_item(logic [IDX_W-1:0] idx, logic [CODE_W-1:0] code,
                                    logic [ENT_LEN_W-1:0] len, logic [SYM_W-1:0] sym);
    in_t item;
    item.operation    = OP_LOAD;
    item.entry_index  = idx;
    item.entry_code   = code;
    item.entry_length = len;
    item.entry_symbol = sym;
    item.coded_byte   = BYTE_W'($urandom);
    return item;
  endfunction

  // fully random load, may well break the current code
  function automatic in_t stray_load();
    return load_item(IDX_W'($urandom), CODE_W'($urandom), ENT_LEN_W'($urandom),
                     SYM_W'($urandom));
  endfunction

  // decode transaction; the table fields are don't-care and get noise
  function automatic in_t decode_item(logic [BYTE_W-1:0] byte_val);
    in_t item;
    item = stray_load();
    item.operation  = OP_DECODE;
    item.coded_byte = byte_val;
    return item;
  endfunction

  // length that is stored but can never match: zero or beyond the limit
  function automatic logic [ENT_LEN_W-1:0] dead_length();
    if ($urandom_range(1) == 0) return '0;
    return ENT_LEN_W'($urandom_range(CODE_LIMIT + 1, 31));
  endfunction

  // bits above the code length must be ignored, so fill them with noise
  function automatic logic [CODE_W-1:0] with_junk_above(logic [CODE_W-1:0] code,
                                                        int unsigned len);
    logic [CODE_W-1:0] keep;
    keep = CODE_W'((32'd1 << len) - 32'd1);
    return (CODE_W'($urandom) & ~keep) | (code & keep);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Valid is only lowered when a gap follows, so it never sees two
  // nonblocking updates in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_t item);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    ledger.absorb_item(item);
    items_sent++;
  endtask

  // Sender holds off until every due symbol is in. The check is made on the
  // falling edge so the result side has already had its say this cycle.
  task automatic hold_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (ledger.pending() != 0);
    @(posedge clk);
  endtask

  // Quiet the decoder fully: nothing due, and long enough for a byte that
  // yields no symbol to finish its scans.
  task automatic settle_decoder();
    in_valid <= 1'b0;
    do @(negedge clk); while (ledger.pending() != 0);
    repeat (BUSY_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.set_total(value);
  endtask

  // --------------------------------------------------------------------------
  // Canonical prefix code table. Lengths are drawn against a Kraft budget in
  // units of 2^-16; a complete table spends the whole budget, so any bit
  // string decodes, while an incomplete one leaves room for overflow.
  // --------------------------------------------------------------------------
  task automatic load_prefix_table(input bit complete);
    int unsigned       lens [$];
    int unsigned       slots [$];
    logic [CODE_W-1:0] codes [$];
    bit                taken [TABLE_SLOTS];
    int unsigned       budget, len, cnt, k, slot_no;
    logic [CODE_W:0]   code;
    budget = 32'h1_0000;
    len    = $urandom_range(1, 4);
    cnt    = $urandom_range(2, 12);
    foreach (taken[i]) taken[i] = 1'b0;
    for (k = 0; k < cnt && budget != 0; k++) begin
      while ((32'd1 << (CODE_LIMIT - len)) > budget) len++;
      lens.push_back(len);
      budget -= 32'd1 << (CODE_LIMIT - len);
      len += $urandom_range(0, 2);
      if (len > CODE_LIMIT) len = CODE_LIMIT;
    end
    // spend what is left, one entry per set bit of the budget
    if (complete) begin
      for (k = 0; k < CODE_LIMIT; k++)
        if (budget[k]) lens.push_back(CODE_LIMIT - k);
    end
    lens.sort();
    code = '0;
    for (k = 0; k < lens.size(); k++) begin
      if (k != 0) code = (code + 1'b1) << (lens[k] - lens[k-1]);
      codes.push_back(code[CODE_W-1:0]);
      do slot_no = $urandom_range(0, TABLE_SLOTS - 1); while (taken[slot_no]);
      taken[slot_no] = 1'b1;
      slots.push_back(slot_no);
    end

    // retire slots of the previous table; now and then leave them standing
    if ($urandom_range(4) != 0) begin
      for (k = 0; k < TABLE_SLOTS; k++)
        if (ledger.slot_live[k] && !taken[k])
          send_item(load_item(IDX_W'(k), CODE_W'($urandom), dead_length(), SYM_W'($urandom)));
    end

    for (k = 0; k < lens.size(); k++)
      send_item(load_item(IDX_W'(slots[k]), with_junk_above(codes[k], lens[k]),
                          ENT_LEN_W'(lens[k]), SYM_W'($urandom)));

    // second copy of a code elsewhere: the lower slot has to win
    if ($urandom_range(1) == 0) begin
      k = $urandom_range(0, lens.size() - 1);
      do slot_no = $urandom_range(0, TABLE_SLOTS - 1); while (taken[slot_no]);
      taken[slot_no] = 1'b1;
      send_item(load_item(IDX_W'(slot_no), with_junk_above(codes[k], lens[k]),
                          ENT_LEN_W'(lens[k]), SYM_W'($urandom)));
    end
    // same code bits under an unusable length: must never fire
    if ($urandom_range(1) == 0) begin
      k = $urandom_range(0, lens.size() - 1);
      do slot_no = $urandom_range(0, TABLE_SLOTS - 1); while (taken[slot_no]);
      taken[slot_no] = 1'b1;
      send_item(load_item(IDX_W'(slot_no), codes[k], dead_length(), SYM_W'($urandom)));
    end
  endtask

  // One random phase: tables followed by streams of coded bytes.
  task automatic run_phase(input int unsigned item_goal);
    int unsigned n, kind;
    while (items_sent < item_goal) begin
      tables_built++;
      // every third table the sender waits for the decoder to empty
      if (tables_built % 3 == 0) hold_for_results();
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // scrambled table: arbitrary slots, codes and lengths
        for (n = $urandom_range(3, 10); n != 0; n--) send_item(stray_load());
      end else begin
        load_prefix_table(kind >= 4);
      end
      for (n = $urandom_range(20, 45); n != 0 && items_sent < item_goal; n--) begin
        if ($urandom_range(19) == 0) send_item(stray_load());
        else send_item(decode_item(BYTE_W'($urandom)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned phase_base;
    ledger = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stream length zero first: the table loads, but no bit is ever used.
    write_total('0);
    send_item(load_item(7'd10,  16'hFFFE, 5'd1,  SYM_SPACE));     // '0', junk above
    send_item(load_item(7'd3,   16'hAAAA, 5'd2,  SYM_LINE_FEED)); // '10'
    send_item(load_item(7'd90,  16'h5556, 5'd2,  8'h5A));         // '10' again, loses
    send_item(load_item(7'd0,   16'h0006, 5'd3,  8'hFF));         // '110'
    send_item(load_item(7'd127, 16'h000E, 5'd4,  8'h00));         // '1110'
    send_item(load_item(7'd20,  16'hF000, 5'd16, 8'hA5));         // full-length code
    send_item(load_item(7'd2,   16'h0000, 5'd0,  8'h77));         // zero length
    send_item(load_item(7'd4,   16'hFFFF, 5'd31, 8'h88));         // beyond the limit
    send_item(decode_item(8'hFF));

    // 13 bits: eight spaces, then five ones held as a partial code and the
    // rest of the stream skipped
    settle_decoder();
    write_total(32'd13);
    send_item(decode_item(8'h00));
    send_item(decode_item(8'hFF));
    send_item(decode_item(8'h00));

    // Open the stream fully; the held bits carry on into an overflow, then
    // 1111 followed by twelve zeros hits the full-length entry.
    settle_decoder();
    write_total('1);
    send_item(decode_item(8'hFF));
    send_item(decode_item(8'h00));
    send_item(decode_item(8'h0F));
    send_item(decode_item(8'h00));
    send_item(decode_item(8'h01));
    send_item(decode_item(8'h55));
    send_item(decode_item(8'hAA));
    send_item(decode_item(8'hC3));
    send_item(decode_item(8'h80));

    phase_base = items_sent;

    // phase 1: sender mostly busy, receiver mostly stalled
    run_phase(phase_base + RANDOM_ITEMS / 3);

    // phase 2: the other way round, with a stream limit somewhere far ahead
    settle_decoder();
    send_gap_pct   = 82;
    recv_stall_pct = 9;
    write_total(ledger.bits_used + CFG_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)));
    run_phase(phase_base + 2 * (RANDOM_ITEMS / 3));

    // phase 3: no idling on either side
    settle_decoder();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_total('1);
    run_phase(phase_base + RANDOM_ITEMS);

    settle_decoder();
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
